/* hdl/positional_audio_gain_pan_macros.svh */
// Assertion helpers, used by the checks in the FIFO.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef POSITIONAL_AUDIO_GAIN_PAN_MACROS_SVH
`define POSITIONAL_AUDIO_GAIN_PAN_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PAGP_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pagp check failed");

// A condition that must hold in the cycle after a trigger.
`define PAGP_CHECK_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("pagp check failed");

`endif

/* hdl/pagp_pkg.sv */
package pagp_pkg;

  localparam int POS_W      = 24;
  localparam int DIFF_W     = 25;
  localparam int RAD_W      = 23;
  localparam int RVEC_W     = 16;
  localparam int VOL_W      = 16;
  localparam int LVL_W      = 16;
  localparam int SQ_W       = 50;
  localparam int DIST_W     = 25;
  localparam int DOT_W      = 43;
  localparam int PROD_W     = 41;
  localparam int VS_W       = 32;
  localparam int GPROD_W    = 48;
  localparam int RATIO_W    = 46;
  localparam int FRAC_SH    = 15;
  localparam int ROLL_NUM_W = RATIO_W + FRAC_SH;
  localparam int QUO_W      = 18;
  localparam int LVL_SQ_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Z    = 3'd5;

  localparam logic [LVL_W-1:0] ONE_Q15  = 16'h8000;
  localparam logic [LVL_W-1:0] HALF_Q15 = 16'h4000;
  localparam logic signed [RVEC_W-1:0] RIGHT_Y_RESET = -16'sd16384;

  typedef struct packed {
    logic signed [POS_W-1:0]  lx;
    logic signed [POS_W-1:0]  ly;
    logic signed [POS_W-1:0]  lz;
    logic signed [RVEC_W-1:0] rx;
    logic signed [RVEC_W-1:0] ry;
    logic signed [RVEC_W-1:0] rz;
  } cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0]         sq;
    logic signed [DOT_W-1:0] dot;
    logic [RAD_W-1:0]        near_rad;
    logic [RAD_W-1:0]        far_rad;
    logic [VOL_W-1:0]        vol;
    logic [VOL_W-1:0]        scl;
  } voice_t;

endpackage

/* hdl/pagp_sqrt.sv */
module pagp_sqrt #(
  parameter int IN_W  = pagp_pkg::SQ_W,
  parameter int TAG_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_W-1:0]      in_rad,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [IN_W/2-1:0]    out_root,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int OUT_W = IN_W / 2;

  logic            vld_r [OUT_W];
  logic [IN_W-1:0] v_r   [OUT_W];
  logic [IN_W-1:0] rt_r  [OUT_W];
  logic [TAG_W-1:0] tag_r [OUT_W];

  // One result bit per stage, most significant first.
  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    localparam logic [IN_W-1:0] BIT = IN_W'(1) << (2 * (OUT_W - 1 - s));
    logic [IN_W-1:0]  v_in;
    logic [IN_W-1:0]  rt_in;
    logic [IN_W-1:0]  trial;
    logic             vld_in;
    logic [TAG_W-1:0] tag_in;

    if (s == 0) begin : g_first
      assign v_in   = in_rad;
      assign rt_in  = '0;
      assign vld_in = in_valid;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign rt_in  = rt_r[s-1];
      assign vld_in = vld_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    assign trial = rt_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          v_r[s]  <= v_in - trial;
          rt_r[s] <= (rt_in >> 1) + BIT;
        end else begin
          v_r[s]  <= v_in;
          rt_r[s] <= rt_in >> 1;
        end
        tag_r[s] <= tag_in;
      end
    end
  end

  assign out_valid = vld_r[OUT_W-1];
  assign out_root  = rt_r[OUT_W-1][OUT_W-1:0];
  assign out_tag   = tag_r[OUT_W-1];

endmodule

/* hdl/pagp_div.sv */
module pagp_div #(
  parameter int NUM_W = pagp_pkg::ROLL_NUM_W,
  parameter int DEN_W = pagp_pkg::RATIO_W,
  parameter int Q_W   = pagp_pkg::QUO_W,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quo,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             vld_r [Q_W];
  logic [CW-1:0]    rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];

  // Restoring division, one quotient bit per stage, most significant first.
  // The quotient is expected to fit in Q_W bits.
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int SH = Q_W - 1 - k;
    logic [CW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic             vld_in;
    logic [TAG_W-1:0] tag_in;
    logic [CW-1:0]    dsh;

    if (k == 0) begin : g_first
      assign rem_in = CW'(in_num);
      assign den_in = in_den;
      assign quo_in = '0;
      assign vld_in = in_valid;
      assign tag_in = in_tag;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign vld_in = vld_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    assign dsh = CW'(den_in) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= dsh) begin
          rem_r[k] <= rem_in - dsh;
          quo_r[k] <= quo_in | (Q_W'(1) << SH);
        end else begin
          rem_r[k] <= rem_in;
          quo_r[k] <= quo_in;
        end
        den_r[k] <= den_in;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule

/* hdl/pagp_fifo.sv */
`include "positional_audio_gain_pan_macros.svh"

module pagp_fifo #(
  parameter int DEPTH = pagp_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pagp_pkg::voice_t push_data,
  input  logic             pop,
  output pagp_pkg::voice_t pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pagp_pkg::voice_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `PAGP_CHECK(fifo_no_overflow, !(push && full))
  `PAGP_CHECK(fifo_no_underflow, !(pop && empty))
  `PAGP_CHECK_NEXT(fifo_count_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

/* hdl/pagp_front.sv */
module pagp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pagp_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pagp_pkg::POS_W-1:0]    in_emitter_x,
  input  logic [pagp_pkg::POS_W-1:0]    in_emitter_y,
  input  logic [pagp_pkg::POS_W-1:0]    in_emitter_z,
  input  logic [pagp_pkg::RAD_W-1:0]    in_near_radius,
  input  logic [pagp_pkg::RAD_W-1:0]    in_far_radius,
  input  logic [pagp_pkg::VOL_W-1:0]    in_sound_volume,
  input  logic [pagp_pkg::VOL_W-1:0]    in_volume_scale,
  input  logic                          fifo_full,
  output logic                          push,
  output pagp_pkg::voice_t              push_data
);

  localparam int DW = pagp_pkg::DIFF_W;
  localparam int PW = pagp_pkg::PROD_W;
  localparam int QW = pagp_pkg::SQ_W;

  logic adv;

  // Stage 1: offsets from the listener.
  logic                  s1_valid_r;
  logic signed [DW-1:0]  dx_r, dy_r, dz_r;
  logic signed [DW-1:0]  dx_nxt, dy_nxt, dz_nxt;
  logic [pagp_pkg::RAD_W-1:0] near1_r, far1_r;
  logic [pagp_pkg::VOL_W-1:0] vol1_r, scl1_r;

  // Stage 2: squared terms and dot terms.
  logic                  s2_valid_r;
  logic signed [QW-1:0]  sqx_nxt, sqy_nxt, sqz_nxt;
  logic [QW-2:0]         sqx_r, sqy_r, sqz_r;
  logic signed [PW-1:0]  px_r, py_r, pz_r;
  logic signed [PW-1:0]  px_nxt, py_nxt, pz_nxt;
  logic [pagp_pkg::RAD_W-1:0] near2_r, far2_r;
  logic [pagp_pkg::VOL_W-1:0] vol2_r, scl2_r;

  assign adv      = !(s2_valid_r && fifo_full);
  assign in_stall = !adv;
  assign push     = s2_valid_r && adv;

  always_comb begin
    dx_nxt = $signed({in_emitter_x[pagp_pkg::POS_W-1], in_emitter_x})
           - $signed({cfg.lx[pagp_pkg::POS_W-1], cfg.lx});
    dy_nxt = $signed({in_emitter_y[pagp_pkg::POS_W-1], in_emitter_y})
           - $signed({cfg.ly[pagp_pkg::POS_W-1], cfg.ly});
    dz_nxt = $signed({in_emitter_z[pagp_pkg::POS_W-1], in_emitter_z})
           - $signed({cfg.lz[pagp_pkg::POS_W-1], cfg.lz});
    sqx_nxt = dx_r * dx_r;
    sqy_nxt = dy_r * dy_r;
    sqz_nxt = dz_r * dz_r;
    px_nxt  = dx_r * cfg.rx;
    py_nxt  = dy_r * cfg.ry;
    pz_nxt  = dz_r * cfg.rz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      dz_r    <= dz_nxt;
      near1_r <= in_near_radius;
      far1_r  <= in_far_radius;
      vol1_r  <= in_sound_volume;
      scl1_r  <= in_volume_scale;
      sqx_r   <= sqx_nxt[QW-2:0];
      sqy_r   <= sqy_nxt[QW-2:0];
      sqz_r   <= sqz_nxt[QW-2:0];
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      near2_r <= near1_r;
      far2_r  <= far1_r;
      vol2_r  <= vol1_r;
      scl2_r  <= scl1_r;
    end
  end

  always_comb begin
    push_data.sq  = {1'b0, sqx_r} + {1'b0, sqy_r} + {1'b0, sqz_r};
    push_data.dot = pagp_pkg::DOT_W'(px_r) + pagp_pkg::DOT_W'(py_r)
                  + pagp_pkg::DOT_W'(pz_r);
    push_data.near_rad = near2_r;
    push_data.far_rad  = far2_r;
    push_data.vol      = vol2_r;
    push_data.scl      = scl2_r;
  end

endmodule

/* hdl/pagp_back.sv */
module pagp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fifo_empty,
  input  pagp_pkg::voice_t            pop_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pagp_pkg::LVL_W-1:0]  out_gain,
  output logic [pagp_pkg::LVL_W-1:0]  out_left_level,
  output logic [pagp_pkg::LVL_W-1:0]  out_right_level,
  output logic                        out_audible
);

  localparam int RW = pagp_pkg::RAD_W;
  localparam int LW = pagp_pkg::LVL_W;
  localparam int QW = pagp_pkg::QUO_W;

  typedef struct packed {
    logic signed [pagp_pkg::DOT_W-1:0] dot;
    logic [RW-1:0]                     near_rad;
    logic [RW-1:0]                     far_rad;
    logic [pagp_pkg::VS_W-1:0]         vs;
  } dist_tag_t;

  typedef struct packed {
    logic                      full;
    logic                      zero;
    logic                      dzero;
    logic [pagp_pkg::VS_W-1:0] vs;
  } roll_tag_t;

  logic adv;

  dist_tag_t                      dtag_in, dtag_out;
  logic                           dist_valid;
  logic [pagp_pkg::DIST_W-1:0]    dist_len;

  logic                           c1_valid_r;
  roll_tag_t                      c1_tag_r, c1_tag_nxt;
  logic [pagp_pkg::RATIO_W-1:0]   num_r, den_r, num_nxt, den_nxt;
  logic [pagp_pkg::DIST_W-1:0]    pden_r, pden_nxt;
  logic [pagp_pkg::DOT_W-1:0]     mag_r, mag_nxt;
  logic                           neg_r;
  logic [RW-1:0]                  fmd, fmn;

  logic                           roll_valid, pan_valid, pan_neg;
  logic [QW-1:0]                  roll_quo, pan_quo;
  roll_tag_t                      roll_tag;

  logic                           d1_valid_r;
  logic [pagp_pkg::GPROD_W-1:0]   prod_r, prod_nxt;
  logic [LW-1:0]                  pan_r, pan_nxt, atten;
  logic [QW-1:0]                  pan_tmp;

  logic [LW-1:0]                  gain_w;
  logic                           aud_w;
  logic [pagp_pkg::LVL_SQ_W-1:0]  left_arg, right_arg;
  logic                           left_valid, right_valid;
  logic [LW-1:0]                  left_root, right_root, gain_q;
  logic                           aud_q;

  logic                           out_valid_r;
  logic [LW-1:0]                  gain_r, left_r, right_r;
  logic                           aud_r;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !fifo_empty;

  assign dtag_in.dot      = pop_data.dot;
  assign dtag_in.near_rad = pop_data.near_rad;
  assign dtag_in.far_rad  = pop_data.far_rad;
  assign dtag_in.vs       = pop_data.vol * pop_data.scl;

  pagp_sqrt #(
    .IN_W  (pagp_pkg::SQ_W),
    .TAG_W ($bits(dist_tag_t))
  ) u_dist_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (!fifo_empty),
    .in_rad    (pop_data.sq),
    .in_tag    (dtag_in),
    .out_valid (dist_valid),
    .out_root  (dist_len),
    .out_tag   (dtag_out)
  );

  // Classify the distance against the radii and set up both divisions.
  always_comb begin
    fmd = dtag_out.far_rad - dist_len[RW-1:0];
    fmn = dtag_out.far_rad - dtag_out.near_rad;
    num_nxt = dtag_out.near_rad * fmd;
    den_nxt = dist_len[RW-1:0] * fmn;
    c1_tag_nxt.full  = (dtag_out.far_rad == '0) || (dist_len <= {2'b00, dtag_out.near_rad});
    c1_tag_nxt.zero  = (dist_len >= {2'b00, dtag_out.far_rad});
    c1_tag_nxt.dzero = (dist_len == '0);
    c1_tag_nxt.vs    = dtag_out.vs;
    if ((dtag_out.near_rad != '0) && (dist_len < {2'b00, dtag_out.near_rad})) begin
      pden_nxt = {2'b00, dtag_out.near_rad};
    end else begin
      pden_nxt = dist_len;
    end
    if (dtag_out.dot[pagp_pkg::DOT_W-1]) begin
      mag_nxt = ~$unsigned(dtag_out.dot) + 1'b1;
    end else begin
      mag_nxt = $unsigned(dtag_out.dot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r <= 1'b0;
    end else if (adv) begin
      c1_valid_r <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_tag_r <= c1_tag_nxt;
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      pden_r   <= pden_nxt;
      mag_r    <= mag_nxt;
      neg_r    <= dtag_out.dot[pagp_pkg::DOT_W-1];
    end
  end

  pagp_div #(
    .NUM_W (pagp_pkg::ROLL_NUM_W),
    .DEN_W (pagp_pkg::RATIO_W),
    .Q_W   (QW),
    .TAG_W ($bits(roll_tag_t))
  ) u_roll_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (c1_valid_r),
    .in_num    ({num_r, {pagp_pkg::FRAC_SH{1'b0}}}),
    .in_den    (den_r),
    .in_tag    (c1_tag_r),
    .out_valid (roll_valid),
    .out_quo   (roll_quo),
    .out_tag   (roll_tag)
  );

  pagp_div #(
    .NUM_W (pagp_pkg::DOT_W),
    .DEN_W (pagp_pkg::DIST_W),
    .Q_W   (QW),
    .TAG_W (1)
  ) u_pan_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (c1_valid_r),
    .in_num    (mag_r),
    .in_den    (pden_r),
    .in_tag    (neg_r),
    .out_valid (pan_valid),
    .out_quo   (pan_quo),
    .out_tag   (pan_neg)
  );

  always_comb begin
    if (roll_tag.full) begin
      atten = pagp_pkg::ONE_Q15;
    end else if (roll_tag.zero) begin
      atten = '0;
    end else begin
      atten = roll_quo[LW-1:0];
    end
    prod_nxt = roll_tag.vs * atten;
    if (pan_neg) begin
      pan_tmp = {2'b00, pagp_pkg::HALF_Q15} - pan_quo;
    end else begin
      pan_tmp = {2'b00, pagp_pkg::HALF_Q15} + pan_quo;
    end
    if (roll_tag.dzero) begin
      pan_nxt = pagp_pkg::HALF_Q15;
    end else if (pan_quo >= {2'b00, pagp_pkg::HALF_Q15}) begin
      pan_nxt = pan_neg ? '0 : pagp_pkg::ONE_Q15;
    end else begin
      pan_nxt = pan_tmp[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_valid_r <= 1'b0;
    end else if (adv) begin
      d1_valid_r <= roll_valid && pan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      pan_r  <= pan_nxt;
    end
  end

  always_comb begin
    if (prod_r[pagp_pkg::GPROD_W-1:24] > {8'h00, pagp_pkg::ONE_Q15}) begin
      gain_w = pagp_pkg::ONE_Q15;
    end else begin
      gain_w = prod_r[39:24];
    end
    aud_w     = (prod_r != '0);
    left_arg  = {1'b0, pagp_pkg::ONE_Q15 - pan_r, {pagp_pkg::FRAC_SH{1'b0}}};
    right_arg = {1'b0, pan_r, {pagp_pkg::FRAC_SH{1'b0}}};
  end

  pagp_sqrt #(
    .IN_W  (pagp_pkg::LVL_SQ_W),
    .TAG_W (LW)
  ) u_left_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (d1_valid_r),
    .in_rad    (left_arg),
    .in_tag    (gain_w),
    .out_valid (left_valid),
    .out_root  (left_root),
    .out_tag   (gain_q)
  );

  pagp_sqrt #(
    .IN_W  (pagp_pkg::LVL_SQ_W),
    .TAG_W (1)
  ) u_right_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (d1_valid_r),
    .in_rad    (right_arg),
    .in_tag    (aud_w),
    .out_valid (right_valid),
    .out_root  (right_root),
    .out_tag   (aud_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= left_valid && right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gain_r  <= gain_q;
      left_r  <= left_root;
      right_r <= right_root;
      aud_r   <= aud_q;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gain        = gain_r;
  assign out_left_level  = left_r;
  assign out_right_level = right_r;
  assign out_audible     = aud_r;

endmodule

/* hdl/positional_audio_gain_pan.sv */
// Positional gain and pan for one voice per transaction. Each input
// transaction carries an emitter position, its near and far radii and two
// volume factors; the block returns one result transaction with a gain
// saturated to 0..1, constant-power left and right levels and an audible
// flag. A new transaction can be taken on every clock while in_stall is low.
// The back end is a chain of pipelined units: a 25-stage square root for
// the distance, two 18-stage dividers that run side by side for the
// rolloff and the pan, and two 16-stage square roots for the levels. The
// listener position and right vector are written through the configuration
// port and should only change while no transaction is in flight.

module positional_audio_gain_pan #(
  parameter int FIFO_DEPTH = pagp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_wr_en,
  input  logic [pagp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pagp_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pagp_pkg::POS_W-1:0] in_emitter_x,
  input  logic signed [pagp_pkg::POS_W-1:0] in_emitter_y,
  input  logic signed [pagp_pkg::POS_W-1:0] in_emitter_z,
  input  logic [pagp_pkg::RAD_W-1:0]        in_near_radius,
  input  logic [pagp_pkg::RAD_W-1:0]        in_far_radius,
  input  logic [pagp_pkg::VOL_W-1:0]        in_sound_volume,
  input  logic [pagp_pkg::VOL_W-1:0]        in_volume_scale,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pagp_pkg::LVL_W-1:0]        out_gain,
  output logic [pagp_pkg::LVL_W-1:0]        out_left_level,
  output logic [pagp_pkg::LVL_W-1:0]        out_right_level,
  output logic                              out_audible
);

  // Configuration registers. Position registers take the full write data;
  // the right vector registers keep its low 16 bits. Unused indexes are
  // dropped.
  pagp_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        pagp_pkg::REG_LISTENER_X: cfg_nxt.lx = cfg_wdata;
        pagp_pkg::REG_LISTENER_Y: cfg_nxt.ly = cfg_wdata;
        pagp_pkg::REG_LISTENER_Z: cfg_nxt.lz = cfg_wdata;
        pagp_pkg::REG_RIGHT_X:    cfg_nxt.rx = cfg_wdata[pagp_pkg::RVEC_W-1:0];
        pagp_pkg::REG_RIGHT_Y:    cfg_nxt.ry = cfg_wdata[pagp_pkg::RVEC_W-1:0];
        pagp_pkg::REG_RIGHT_Z:    cfg_nxt.rz = cfg_wdata[pagp_pkg::RVEC_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lx <= '0;
      cfg_r.ly <= '0;
      cfg_r.lz <= '0;
      cfg_r.rx <= '0;
      cfg_r.ry <= pagp_pkg::RIGHT_Y_RESET;
      cfg_r.rz <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end forms the offset, the squared length and the dot product
  // and hands each voice to the queue. The back end drains the queue at its
  // own pace, so an output stall only reaches the input once the queue is
  // full.
  logic             push, pop, fifo_full, fifo_empty;
  pagp_pkg::voice_t push_data, pop_data;

  pagp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_emitter_x    (in_emitter_x),
    .in_emitter_y    (in_emitter_y),
    .in_emitter_z    (in_emitter_z),
    .in_near_radius  (in_near_radius),
    .in_far_radius   (in_far_radius),
    .in_sound_volume (in_sound_volume),
    .in_volume_scale (in_volume_scale),
    .fifo_full       (fifo_full),
    .push            (push),
    .push_data       (push_data)
  );

  pagp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  // The back end holds the result in its output register while the
  // consumer stalls, and the whole back pipeline freezes with it.
  pagp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_empty      (fifo_empty),
    .pop_data        (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gain        (out_gain),
    .out_left_level  (out_left_level),
    .out_right_level (out_right_level),
    .out_audible     (out_audible)
  );

endmodule
